>>> rtl/mvor_pkg.sv
// shared types, codes and defaults for the vertex one-ring block
package mvor_pkg;

  localparam int MaxVerticesDef  = 1024;
  localparam int MaxTrianglesDef = 2048;
  localparam int MaxValenceDef   = 16;

  localparam int IdxW   = 10;
  localparam int VcntW  = 11;
  localparam int TriW   = 3 * IdxW;

  localparam logic [VcntW-1:0] VcountReset = 11'd1024;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ISOLATED  = 3'd1,
    ST_OPEN      = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_EMIT,
    S_ERR
  } state_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdxW-1:0] corner_a;
    logic [IdxW-1:0] corner_b;
    logic [IdxW-1:0] corner_c;
    logic [IdxW-1:0] query_vertex;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] neighbor;
    logic [2:0]      status;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic    load_write;
    logic    clear;
    logic    scan_start;
    logic    scan_run;
    logic    walk_init;
    logic    walk_step;
    logic    push_ring;
    logic    push_err;
    logic    set_err;
    status_e err_code;
  } cmd_t;

  typedef struct packed {
    logic load_bad;
    logic load_full;
    logic query_bad;
    logic scan_done;
    logic found;
    logic too_long;
    logic walk_open;
    logic walk_closed;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

>>> rtl/mvor_ram.sv
// generic single-write, single-read ram with registered read data
module mvor_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/mvor_ctrl.sv
// controller state machine for load, scan, ring walk and result emission
module mvor_ctrl import mvor_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] kind_i,
  output logic       in_stall_o,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_e'(kind_i))
            KIND_LOAD: begin
              if (stat_i.load_bad || stat_i.load_full) state_d = S_ERR;
            end
            KIND_QUERY: state_d = stat_i.query_bad ? S_ERR : S_SCAN;
            KIND_CLEAR: state_d = S_IDLE;
            KIND_NONE:  state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = (!stat_i.found || stat_i.too_long) ? S_ERR : S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.walk_open) state_d = S_ERR;
        else if (stat_i.walk_closed) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free && stat_i.emit_last) state_d = S_IDLE;
      end
      S_ERR: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.err_code = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_e'(kind_i))
            KIND_LOAD: begin
              if (stat_i.load_bad) begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = ST_BAD_INDEX;
              end else if (stat_i.load_full) begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = ST_FULL;
              end else begin
                cmd_o.load_write = 1'b1;
              end
            end
            KIND_QUERY: begin
              if (stat_i.query_bad) begin
                cmd_o.set_err  = 1'b1;
                cmd_o.err_code = ST_BAD_INDEX;
              end else begin
                cmd_o.scan_start = 1'b1;
              end
            end
            KIND_CLEAR: cmd_o.clear = 1'b1;
            KIND_NONE:  cmd_o.clear = 1'b0;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          if (!stat_i.found) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ST_ISOLATED;
          end else if (stat_i.too_long) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = ST_TOO_LONG;
          end else begin
            cmd_o.walk_init = 1'b1;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_open) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = ST_OPEN;
        end
      end
      S_EMIT: cmd_o.push_ring = stat_i.out_free;
      S_ERR:  cmd_o.push_err  = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> rtl/mvor_dp.sv
// datapath: triangle store, successor pairs, ring buffer and output register
module mvor_dp import mvor_pkg::*; #(
  parameter int MAX_VERTICES  = MaxVerticesDef,
  parameter int MAX_TRIANGLES = MaxTrianglesDef,
  parameter int MAX_VALENCE   = MaxValenceDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [VcntW-1:0] cfg_wdata_i,
  input  in_item_t         in_item_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output out_item_t        out_item_o,
  input  cmd_t             cmd_i,
  output stat_t            stat_o
);

  localparam int AW  = $clog2(MAX_TRIANGLES);
  localparam int TCW = $clog2(MAX_TRIANGLES + 1);
  localparam int PCW = $clog2(MAX_VALENCE + 1);
  localparam int RIW = $clog2(MAX_VALENCE);

  logic [VcntW-1:0] vcount_q;
  logic [TCW-1:0]   tcount_q;
  logic [TCW-1:0]   t_q;
  logic             rd_pend_q;
  logic             rd_en;
  logic [TriW-1:0]  rd_data;
  logic [IdxW-1:0]  qv_q;
  status_e          err_q;

  logic [IdxW-1:0] key_q [MAX_VALENCE];
  logic [IdxW-1:0] val_q [MAX_VALENCE];
  logic [IdxW-1:0] key_d [MAX_VALENCE];
  logic [IdxW-1:0] val_d [MAX_VALENCE];
  logic [PCW-1:0]  pcount_q, pcount_d;
  logic            found_q, found_d;
  logic            tlong_q, tlong_d;
  logic [IdxW-1:0] start_q, start_d;

  logic [IdxW-1:0] ring_q [MAX_VALENCE];
  logic [IdxW-1:0] idx_q;
  logic [PCW-1:0]  n_q;
  logic [PCW-1:0]  k_q;

  logic            w_hit;
  logic [IdxW-1:0] w_val;
  logic            w_open, w_closed;

  logic            out_valid_q;
  out_item_t       out_q;

  function automatic logic idx_ok(input logic [IdxW-1:0] v, input logic [VcntW-1:0] vc);
    return ({1'b0, v} < vc) && (32'(v) < 32'(MAX_VERTICES));
  endfunction

  mvor_ram #(.WIDTH(TriW), .DEPTH(MAX_TRIANGLES)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_write),
    .waddr_i (tcount_q[AW-1:0]),
    .wdata_i ({in_item_i.corner_c, in_item_i.corner_b, in_item_i.corner_a}),
    .raddr_i (t_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_en = cmd_i.scan_run && (t_q != tcount_q) && !tlong_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q  <= VcountReset;
      tcount_q  <= '0;
      t_q       <= '0;
      rd_pend_q <= 1'b0;
      pcount_q  <= '0;
      found_q   <= 1'b0;
      tlong_q   <= 1'b0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (cmd_i.clear) tcount_q <= '0;
      else if (cmd_i.load_write) tcount_q <= tcount_q + TCW'(1);
      if (cmd_i.scan_start) t_q <= '0;
      else if (rd_en) t_q <= t_q + TCW'(1);
      rd_pend_q <= rd_en;
      pcount_q  <= pcount_d;
      found_q   <= found_d;
      tlong_q   <= tlong_d;
    end
  end

  // apply the three corners of one triangle in order
  always_comb begin
    logic [IdxW-1:0] c_v [3];
    logic [IdxW-1:0] key_v, val_v;
    logic            hit_v;
    key_d    = key_q;
    val_d    = val_q;
    pcount_d = pcount_q;
    found_d  = found_q;
    tlong_d  = tlong_q;
    start_d  = start_q;
    key_v    = '0;
    val_v    = '0;
    hit_v    = 1'b0;
    c_v[0] = rd_data[IdxW-1:0];
    c_v[1] = rd_data[2*IdxW-1:IdxW];
    c_v[2] = rd_data[3*IdxW-1:2*IdxW];
    if (cmd_i.scan_start) begin
      pcount_d = '0;
      found_d  = 1'b0;
      tlong_d  = 1'b0;
    end else if (rd_pend_q && !tlong_q) begin
      for (int k = 0; k < 3; k++) begin
        key_v = c_v[(k + 1) % 3];
        val_v = c_v[(k + 2) % 3];
        if (!tlong_d && (c_v[k] == qv_q)) begin
          if (!found_d) begin
            start_d = key_v;
            found_d = 1'b1;
          end
          hit_v = 1'b0;
          for (int i = 0; i < MAX_VALENCE; i++) begin
            if ((PCW'(i) < pcount_d) && (key_d[i] == key_v)) begin
              val_d[i] = val_v;
              hit_v    = 1'b1;
            end
          end
          if (!hit_v) begin
            if (pcount_d < PCW'(MAX_VALENCE)) begin
              for (int i = 0; i < MAX_VALENCE; i++) begin
                if (PCW'(i) == pcount_d) begin
                  key_d[i] = key_v;
                  val_d[i] = val_v;
                end
              end
              pcount_d = pcount_d + PCW'(1);
            end else begin
              tlong_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    val_q   <= val_d;
    start_q <= start_d;
    if (cmd_i.scan_start) qv_q <= in_item_i.query_vertex;
    if (cmd_i.set_err) err_q <= cmd_i.err_code;
  end

  // successor lookup for the ring walk
  always_comb begin
    w_hit = 1'b0;
    w_val = '0;
    for (int i = 0; i < MAX_VALENCE; i++) begin
      if ((PCW'(i) < pcount_q) && (key_q[i] == idx_q)) begin
        w_hit = 1'b1;
        w_val = w_val | val_q[i];
      end
    end
    w_closed = w_hit && (w_val == start_q);
    w_open   = !w_hit || (!w_closed &&
               ((n_q >= pcount_q) || (n_q >= PCW'(MAX_VALENCE))));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      ring_q[0] <= start_q;
      idx_q     <= start_q;
      n_q       <= PCW'(1);
      k_q       <= '0;
    end else begin
      if (cmd_i.walk_step && !w_open && !w_closed) begin
        ring_q[n_q[RIW-1:0]] <= w_val;
        idx_q <= w_val;
        n_q   <= n_q + PCW'(1);
      end
      if (cmd_i.push_ring) k_q <= k_q + PCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_ring || cmd_i.push_err) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_ring) begin
      out_q.neighbor <= ring_q[k_q[RIW-1:0]];
      out_q.status   <= ST_OK;
      out_q.last     <= (k_q + PCW'(1) == n_q);
    end else if (cmd_i.push_err) begin
      out_q.neighbor <= '0;
      out_q.status   <= err_q;
      out_q.last     <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    stat_o.load_bad    = !idx_ok(in_item_i.corner_a, vcount_q) ||
                         !idx_ok(in_item_i.corner_b, vcount_q) ||
                         !idx_ok(in_item_i.corner_c, vcount_q);
    stat_o.load_full   = (tcount_q >= TCW'(MAX_TRIANGLES));
    stat_o.query_bad   = !idx_ok(in_item_i.query_vertex, vcount_q);
    stat_o.scan_done   = ((t_q == tcount_q) || tlong_q) && !rd_pend_q;
    stat_o.found       = found_q;
    stat_o.too_long    = tlong_q;
    stat_o.walk_open   = w_open;
    stat_o.walk_closed = w_closed;
    stat_o.out_free    = !out_valid_q || !out_stall_i;
    stat_o.emit_last   = (k_q + PCW'(1) == n_q);
  end

  a_pcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcount_q <= PCW'(MAX_VALENCE)) else $error("pair count above valence limit");

  a_walk_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> (n_q != '0) && (n_q <= pcount_q))
    else $error("ring length out of pair range during walk");

  a_emit_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_ring |-> (k_q < n_q)) else $error("emit beyond ring length");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push_ring || cmd_i.push_err) |-> (!out_valid_q || !out_stall_i))
    else $error("push into occupied output register");

endmodule

>>> rtl/mesh_vertex_one_ring_core.sv
// top level of the vertex one-ring block
// load and clear are done on acceptance; a rejected item moves to the error state, which
// then pushes its error result into the output register; a query runs the triangle scan
// (one stored triangle per cycle from the triangle ram), then the ring walk and emission
// for a ring of R neighbors; one item is in work at a time
// reset (async, active low) empties the triangle table and sets vertex_count to 1024
module mesh_vertex_one_ring_core import mvor_pkg::*; #(
  parameter int MAX_VERTICES  = MaxVerticesDef,
  parameter int MAX_TRIANGLES = MaxTrianglesDef,
  parameter int MAX_VALENCE   = MaxValenceDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [VcntW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o
);

  cmd_t  cmd;
  stat_t stat;

  mvor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (in_item_i.kind),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mvor_dp #(
    .MAX_VERTICES  (MAX_VERTICES),
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .MAX_VALENCE   (MAX_VALENCE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
